FILE: rtl/stun_message_parser_defines.svh
// Assertion macros for the STUN message parser checker.
`ifndef STUN_MESSAGE_PARSER_DEFINES_SVH
`define STUN_MESSAGE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/smp_pkg.sv
// Package of types and constants for the STUN message parser.
`timescale 1ns / 1ps
package smp_pkg;

  localparam int POS_W     = 17;
  localparam int CFG_IDX_W = 8;
  localparam int OUT_W     = 200;

  localparam logic [POS_W-1:0] HDR_BYTES   = 17'd20;
  localparam logic [POS_W-1:0] ALIGN_BYTES = 17'd4;
  localparam logic [POS_W-1:0] POS_SAT     = 17'd65556;
  localparam logic [POS_W-1:0] NO_COLON    = 17'h1FFFF;
  localparam logic [7:0]       COLON_CHAR  = 8'h3A;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_USERNAME        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CANDIDATE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ICE_CONTROLLED  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ICE_CONTROLLING = 8'd3;

  typedef struct packed {
    logic [15:0] username;
    logic [15:0] use_candidate;
    logic [15:0] ice_controlled;
    logic [15:0] ice_controlling;
  } cfg_t;

  // Listed from the top bit down, so status sits in the lowest bits.
  typedef struct packed {
    logic             fill;
    logic [15:0]      colon_index;
    logic [15:0]      ufrag_len;
    logic [POS_W-1:0] ufrag_start;
    logic [15:0]      user_len;
    logic [POS_W-1:0] user_start;
    logic             ice_controlling;
    logic             ice_controlled;
    logic             use_candidate;
    logic [63:0]      tid_low;
    logic [31:0]      tid_high;
    logic [15:0]      message_type;
    logic [1:0]       status;
  } res_t;

endpackage

FILE: rtl/stun_message_parser.sv
// Top level of the STUN message parser: config registers, parse core, result stage.
`timescale 1ns / 1ps
// STUN message parser. Feed a message one byte per transaction on in_, network
// order, with in_tlast on its final byte; a byte is taken every cycle with
// in_tready high. Each message yields exactly one result transaction on out_,
// registered in the output or skid slot. Only the byte marked last produces a
// result; all parse state clears right after it. in_tready drops only while
// both result slots (output register and skid slot) hold untaken results, so
// the input keeps moving through one stalled result. Statuses: ok, shorter
// than 20 bytes (all other fields zero), length mismatch against 20 plus the
// header length (only type and transaction id kept), attribute truncated
// (attributes before it are kept). The magic cookie is not checked. The four
// attribute type codes come from cfg_ registers 0 to 3 (Username,
// USE-CANDIDATE, ICE-CONTROLLED, ICE-CONTROLLING, matched in that priority);
// writes to other indexes are dropped. Write config only while idle.
module stun_message_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  // input byte stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // last_byte
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] status, [17:2] message_type, [49:18] tid_high, [113:50] tid_low,
  // [114] use_candidate, [115] ice_controlled, [116] ice_controlling,
  // [133:117] user_start, [149:134] user_len, [166:150] ufrag_start,
  // [182:167] ufrag_len, [198:183] colon_index, [199] zero
  output logic [smp_pkg::OUT_W-1:0]      out_tdata,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [smp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);
  import smp_pkg::*;

  cfg_t cfg_r;
  logic in_fire;
  logic res_valid;
  res_t res;
  res_t out_res;

  // Config writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.username        <= 16'h0006;
      cfg_r.use_candidate   <= 16'h0025;
      cfg_r.ice_controlled  <= 16'h8029;
      cfg_r.ice_controlling <= 16'h802A;
    end else if (cfg_valid && cfg_ready) begin
      // Drop writes to unknown indexes.
      unique case (cfg_index)
        CFG_USERNAME:        cfg_r.username        <= cfg_data;
        CFG_USE_CANDIDATE:   cfg_r.use_candidate   <= cfg_data;
        CFG_ICE_CONTROLLED:  cfg_r.ice_controlled  <= cfg_data;
        CFG_ICE_CONTROLLING: cfg_r.ice_controlling <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_fire = in_tvalid && in_tready;

  smp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  smp_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = out_res;

endmodule

FILE: rtl/smp_parse_core.sv
// Per-byte parse state and the result built on the last byte of a message.
`timescale 1ns / 1ps
module smp_parse_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smp_pkg::cfg_t        cfg,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 res_valid,
  output smp_pkg::res_t        res
);
  import smp_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TLV    = 3'd1;
  localparam logic [2:0] PH_VALUE  = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_IGNORE = 3'd4;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [15:0]      type_r, type_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [31:0]      tidh_r, tidh_nxt;
  logic [63:0]      tidl_r, tidl_nxt;
  logic [15:0]      kind_r, kind_nxt;
  logic [15:0]      size_r, size_nxt;
  logic [15:0]      left_r, left_nxt;
  logic [1:0]       hcnt_r, hcnt_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [POS_W-1:0] abeg_r, abeg_nxt;
  logic [POS_W-1:0] colp_r, colp_nxt;
  logic [POS_W-1:0] ubeg_r, ubeg_nxt;
  logic [15:0]      usize_r, usize_nxt;
  logic [POS_W-1:0] fbeg_r, fbeg_nxt;
  logic [15:0]      fsize_r, fsize_nxt;
  logic [15:0]      colon_r, colon_nxt;
  logic [2:0]       flags_r, flags_nxt;
  logic             trunc_r, trunc_nxt;

  logic [POS_W-1:0] q;
  logic [POS_W-1:0] total;
  logic             fin_val;
  logic             bound;
  logic [1:0]       pad_v;

  assign q     = pos_r + 17'd1;
  assign total = HDR_BYTES + {1'b0, len_r};

  always_comb begin
    pos_nxt   = (q > POS_SAT) ? POS_SAT : q;
    phase_nxt = phase_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    tidh_nxt  = tidh_r;
    tidl_nxt  = tidl_r;
    kind_nxt  = kind_r;
    size_nxt  = size_r;
    left_nxt  = left_r;
    hcnt_nxt  = hcnt_r;
    pad_nxt   = pad_r;
    abeg_nxt  = abeg_r;
    colp_nxt  = colp_r;
    ubeg_nxt  = ubeg_r;
    usize_nxt = usize_r;
    fbeg_nxt  = fbeg_r;
    fsize_nxt = fsize_r;
    colon_nxt = colon_r;
    flags_nxt = flags_r;
    trunc_nxt = trunc_r;
    fin_val   = 1'b0;
    bound     = 1'b0;
    pad_v     = 2'd0;

    unique case (phase_r)
      PH_HEADER: begin
        priority if (pos_r < 17'd2) begin
          type_nxt = {type_r[7:0], in_byte};
        end else if (pos_r < 17'd4) begin
          len_nxt = {len_r[7:0], in_byte};
        end else if (pos_r < 17'd8) begin
          // magic cookie, skip
        end else if (pos_r < 17'd12) begin
          tidh_nxt = {tidh_r[23:0], in_byte};
        end else if (pos_r < HDR_BYTES) begin
          tidl_nxt = {tidl_r[55:0], in_byte};
        end
        if (pos_r == HDR_BYTES - 17'd1) bound = 1'b1;
      end
      PH_TLV: begin
        hcnt_nxt = hcnt_r + 2'd1;
        if (hcnt_r < 2'd2) kind_nxt = {kind_r[7:0], in_byte};
        else               size_nxt = {size_r[7:0], in_byte};
        if (hcnt_r == 2'd3) begin
          abeg_nxt = q;
          colp_nxt = NO_COLON;
          if ((total - q) < {1'b0, size_nxt}) begin
            trunc_nxt = 1'b1;
            phase_nxt = PH_IGNORE;
          end else if (size_nxt == 16'd0) begin
            fin_val = 1'b1;
          end else begin
            left_nxt  = size_nxt;
            phase_nxt = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        if (in_byte == COLON_CHAR && colp_r == NO_COLON)
          colp_nxt = {1'b0, size_r - left_r};
        left_nxt = left_r - 16'd1;
        if (left_nxt == 16'd0) fin_val = 1'b1;
      end
      PH_PAD: begin
        pad_nxt = pad_r - 2'd1;
        if (pad_nxt == 2'd0 || q >= total) bound = 1'b1;
      end
      default: begin
        // ignore the rest of the message
      end
    endcase

    // Close the attribute: record it, then pad or move to the next record.
    if (fin_val) begin
      priority if (kind_nxt == cfg.username) begin
        ubeg_nxt  = abeg_nxt;
        usize_nxt = size_nxt;
        if (colp_nxt != NO_COLON) begin
          fbeg_nxt  = abeg_nxt;
          fsize_nxt = size_nxt;
          colon_nxt = colp_nxt[15:0];
        end
      end else if (kind_nxt == cfg.use_candidate) begin
        flags_nxt[0] = 1'b1;
      end else if (kind_nxt == cfg.ice_controlled) begin
        flags_nxt[1] = 1'b1;
      end else if (kind_nxt == cfg.ice_controlling) begin
        flags_nxt[2] = 1'b1;
      end else begin
        // unknown attribute, skip its value
      end
      pad_v   = 2'd0 - size_nxt[1:0];
      pad_nxt = pad_v;
      if (pad_v != 2'd0 && q < total) phase_nxt = PH_PAD;
      else                            bound     = 1'b1;
    end

    // Start a new record only if its 4-byte header fits.
    if (bound) begin
      if (q + ALIGN_BYTES <= total) begin
        phase_nxt = PH_TLV;
        hcnt_nxt  = 2'd0;
        kind_nxt  = 16'd0;
        size_nxt  = 16'd0;
      end else begin
        phase_nxt = PH_IGNORE;
      end
    end
  end

  always_comb begin
    res = '0;
    if (pos_nxt < HDR_BYTES) begin
      res.status = ST_SHORT;
    end else begin
      res.message_type = type_nxt;
      res.tid_high     = tidh_nxt;
      res.tid_low      = tidl_nxt;
      if (pos_nxt != HDR_BYTES + {1'b0, len_nxt}) begin
        res.status = ST_MISMATCH;
      end else begin
        res.status          = trunc_nxt ? ST_TRUNC : ST_OK;
        res.use_candidate   = flags_nxt[0];
        res.ice_controlled  = flags_nxt[1];
        res.ice_controlling = flags_nxt[2];
        res.user_start      = ubeg_nxt;
        res.user_len        = usize_nxt;
        res.ufrag_start     = fbeg_nxt;
        res.ufrag_len       = fsize_nxt;
        res.colon_index     = colon_nxt;
      end
    end
  end

  assign res_valid = in_fire && in_last;

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_last)) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      type_r  <= '0;
      len_r   <= '0;
      tidh_r  <= '0;
      tidl_r  <= '0;
      kind_r  <= '0;
      size_r  <= '0;
      left_r  <= '0;
      hcnt_r  <= '0;
      pad_r   <= '0;
      abeg_r  <= '0;
      colp_r  <= NO_COLON;
      ubeg_r  <= '0;
      usize_r <= '0;
      fbeg_r  <= '0;
      fsize_r <= '0;
      colon_r <= '0;
      flags_r <= '0;
      trunc_r <= 1'b0;
    end else if (in_fire) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      tidh_r  <= tidh_nxt;
      tidl_r  <= tidl_nxt;
      kind_r  <= kind_nxt;
      size_r  <= size_nxt;
      left_r  <= left_nxt;
      hcnt_r  <= hcnt_nxt;
      pad_r   <= pad_nxt;
      abeg_r  <= abeg_nxt;
      colp_r  <= colp_nxt;
      ubeg_r  <= ubeg_nxt;
      usize_r <= usize_nxt;
      fbeg_r  <= fbeg_nxt;
      fsize_r <= fsize_nxt;
      colon_r <= colon_nxt;
      flags_r <= flags_nxt;
      trunc_r <= trunc_nxt;
    end
  end

endmodule

FILE: rtl/smp_out_skid.sv
// Two-slot result register: output stage plus skid slot.
`timescale 1ns / 1ps
module smp_out_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  smp_pkg::res_t        push_data,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smp_pkg::res_t        out_data
);
  import smp_pkg::*;

  logic main_v_r;
  logic skid_v_r;
  res_t main_r;
  res_t skid_r;

  assign room      = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      if (skid_v_r)  main_r <= skid_r;
      else if (push) main_r <= push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

FILE: rtl/smp_checker.sv
// Port-level checks on the STUN message parser, bound to its top level.
`timescale 1ns / 1ps
`include "stun_message_parser_defines.svh"
module smp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [smp_pkg::OUT_W-1:0]      out_tdata
);
  import smp_pkg::*;

  res_t view;
  assign view = res_t'(out_tdata);

  // A stalled result holds.
  `SMP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // A short message reports nothing but its status.
  `SMP_ASSERT_NOW(a_short_zero, out_tvalid && view.status == ST_SHORT, out_tdata[OUT_W-1:2] == '0, "short message carries data")

  // A length mismatch keeps only type and transaction id.
  `SMP_ASSERT_NOW(a_mismatch_zero, out_tvalid && view.status == ST_MISMATCH, !view.use_candidate && !view.ice_controlled && !view.ice_controlling && view.user_len == 16'd0 && view.ufrag_len == 16'd0 && view.colon_index == 16'd0, "mismatch carries attributes")

  // The colon lies inside the recorded Username value.
  `SMP_ASSERT_NOW(a_colon_inside, out_tvalid && view.ufrag_len != 16'd0, view.colon_index < view.ufrag_len, "colon outside ufrag value")

  // A new result follows an accepted last byte.
  `SMP_ASSERT_NOW(a_result_cause, $rose(out_tvalid), $past(in_tvalid && in_tready && in_tlast), "result without a last byte")

endmodule

bind stun_message_parser smp_checker u_smp_checker (.*);
